>>> rtl/core/gn2d_pkg.sv
// Shared constants, widths and types of the 2-D gradient noise pipeline.
// No dependencies; every module of the block imports this package.
package gn2d_pkg;

  localparam int TABLE_DEPTH     = 1024;
  localparam int COORD_FRAC_BITS = 12;
  localparam int COORD_INT_BITS  = 12;

  localparam int HASH_ROW_MUL = 41;
  localparam int HASH_COL_MUL = 43;

  localparam int COORD_W = 24;
  localparam int ENTRY_W = 10;
  localparam int GRAD_W  = 16;
  localparam int NOISE_W = 16;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CW    = COORD_INT_BITS + COORD_FRAC_BITS;
  localparam int XW    = (CW > COORD_W) ? CW : COORD_W;
  localparam int EXT_W = (AW + 1 > ENTRY_W) ? AW + 1 : ENTRY_W;

  // hash sum width: 84 * 2^COORD_INT_BITS < 2^(COORD_INT_BITS + 7)
  localparam int HW    = COORD_INT_BITS + 7;
  localparam int RECIP = (1 << HW) / TABLE_DEPTH;

  localparam int A2W = 2 * COORD_FRAC_BITS;
  localparam int EW  = 3 * COORD_FRAC_BITS + 2;
  localparam int OW  = COORD_FRAC_BITS + 1;
  localparam int DW  = COORD_FRAC_BITS + 18;
  localparam int BW  = DW + COORD_FRAC_BITS + 3;
  localparam int RW  = DW - COORD_FRAC_BITS + 1;

  localparam int HALF_F  = 1 << (COORD_FRAC_BITS - 1);
  localparam int SAT_MAX = 32767;
  localparam int SAT_MIN = -32768;

  localparam int NUM_STAGES = 10;
  localparam int RAM_STAGE  = 3;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_e;

  typedef logic [AW-1:0] idx_t;

  typedef struct packed {
    logic [COORD_FRAC_BITS-1:0] fx;
    logic [COORD_FRAC_BITS-1:0] fy;
    logic [COORD_FRAC_BITS:0]   ex;
    logic [COORD_FRAC_BITS:0]   ey;
  } frac_t;

  typedef struct packed {
    logic [ENTRY_W-1:0]       idx;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
  } wr_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gy;
    logic signed [GRAD_W-1:0] gx;
  } grad_t;

endpackage

>>> rtl/core/gradient_noise_2d.sv
// Two-dimensional gradient noise with a loadable gradient table: a write item
// stores one Q1.14 gradient, an evaluate item at a Q12.12 point returns one
// saturated Q1.14 noise value. The block takes one item per clock unless the
// pipe is stalled and returns an evaluate's value through its ten register
// stages; the four corner reads come from two table copies with two read
// ports each, so the table never holds the pipe back. A write item passes the
// first three stages and lands in the table in order with evaluates, so every
// evaluate sees all writes taken before it. The table is not cleared: read
// only entries that have been written. Empty stages fill while full ones ahead
// hold, so input is taken at a stalled output until no stage is empty.
// Depends on gn2d_pkg, gn2d_hash, gn2d_grad_ram and gn2d_blend.
module gradient_noise_2d (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cmd_i,
  input  logic [gn2d_pkg::COORD_W-1:0]        x_coord_i,
  input  logic [gn2d_pkg::COORD_W-1:0]        y_coord_i,
  input  logic [gn2d_pkg::ENTRY_W-1:0]        entry_index_i,
  input  logic signed [gn2d_pkg::GRAD_W-1:0]  grad_x_i,
  input  logic signed [gn2d_pkg::GRAD_W-1:0]  grad_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [gn2d_pkg::NOISE_W-1:0] noise_value_o
);
  import gn2d_pkg::*;

  logic [NUM_STAGES-1:0] en, vq_d, vq_q;
  cmd_e                  cmd3;
  wr_t                   wr3;
  idx_t [3:0]            idx3;
  frac_t                 frac3, frac4;
  grad_t [3:0]           grad4;
  logic                  wr_en;

  // advance a stage when it is empty or the stage after it advances
  always_comb begin
    en[NUM_STAGES-1] = !vq_q[NUM_STAGES-1] || !out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vq_q[k] || en[k+1];
    end
  end

  // shift valid bits forward; drop write items once they reach the table
  always_comb begin
    vq_d = vq_q;
    if (en[0]) begin
      vq_d[0] = in_valid_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        vq_d[k] = vq_q[k-1];
      end
    end
    if (en[RAM_STAGE]) begin
      vq_d[RAM_STAGE] = vq_q[RAM_STAGE-1] && (cmd3 == CMD_EVAL);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq_q <= '0;
    end else begin
      vq_q <= vq_d;
    end
  end

  assign wr_en = en[RAM_STAGE] && vq_q[RAM_STAGE-1] && (cmd3 == CMD_WRITE);

  gn2d_hash u_hash (
    .clk_i         (clk_i),
    .en_i          (en[RAM_STAGE-1:0]),
    .cmd_i         (cmd_i),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .entry_index_i (entry_index_i),
    .grad_x_i      (grad_x_i),
    .grad_y_i      (grad_y_i),
    .cmd_o         (cmd3),
    .wr_o          (wr3),
    .idx_o         (idx3),
    .frac_o        (frac3)
  );

  gn2d_grad_ram u_grad_ram (
    .clk_i   (clk_i),
    .en_i    (en[RAM_STAGE]),
    .wr_en_i (wr_en),
    .wr_i    (wr3),
    .idx_i   (idx3),
    .frac_i  (frac3),
    .grad_o  (grad4),
    .frac_o  (frac4)
  );

  gn2d_blend u_blend (
    .clk_i         (clk_i),
    .en_i          (en[NUM_STAGES-1:RAM_STAGE+1]),
    .grad_i        (grad4),
    .frac_i        (frac4),
    .noise_value_o (noise_value_o)
  );

  assign in_stall_o  = !en[0];
  assign out_valid_o = vq_q[NUM_STAGES-1];

endmodule

>>> rtl/core/gn2d_hash.sv
// Front stages: split coordinates, hash the four corner cells, reduce modulo
// the table depth and compute both ease weights. Depends on gn2d_pkg.
module gn2d_hash (
  input  logic                                 clk_i,
  input  logic [gn2d_pkg::RAM_STAGE-1:0]       en_i,
  input  logic                                 cmd_i,
  input  logic [gn2d_pkg::COORD_W-1:0]         x_coord_i,
  input  logic [gn2d_pkg::COORD_W-1:0]         y_coord_i,
  input  logic [gn2d_pkg::ENTRY_W-1:0]         entry_index_i,
  input  logic signed [gn2d_pkg::GRAD_W-1:0]   grad_x_i,
  input  logic signed [gn2d_pkg::GRAD_W-1:0]   grad_y_i,
  output gn2d_pkg::cmd_e                       cmd_o,
  output gn2d_pkg::wr_t                        wr_o,
  output gn2d_pkg::idx_t [3:0]                 idx_o,
  output gn2d_pkg::frac_t                      frac_o
);
  import gn2d_pkg::*;

  typedef logic [HW-1:0] hash_t;

  function automatic logic [COORD_FRAC_BITS:0] ease(input logic [A2W-1:0] a2,
                                                    input logic [COORD_FRAC_BITS-1:0] a);
    logic [EW-1:0] s;
    s = ((EW'(a2) * EW'(3)) << COORD_FRAC_BITS) - EW'(a2) * EW'(a) * EW'(2)
        + (EW'(1) << (2 * COORD_FRAC_BITS - 1));
    return s[2*COORD_FRAC_BITS +: COORD_FRAC_BITS+1];
  endfunction

  logic [XW-1:0]             x_ext, y_ext;
  logic [CW-1:0]             xc, yc;
  logic [COORD_INT_BITS-1:0] col, row;
  hash_t                     h_base;
  hash_t [3:0]               h_d;
  logic [2*HW-1:0]           prod [4];
  hash_t [3:0]               q_d;
  hash_t                     rem [4];
  idx_t [3:0]                idx_d;

  cmd_e                       cmd1_q, cmd2_q, cmd3_q;
  wr_t                        wr1_q, wr2_q, wr3_q;
  hash_t [3:0]                h1_q, h2_q, q2_q;
  logic [COORD_FRAC_BITS-1:0] fx1_q, fy1_q, fx2_q, fy2_q;
  logic [A2W-1:0]             a2x1_q, a2y1_q;
  logic [COORD_FRAC_BITS:0]   ex2_q, ey2_q;
  idx_t [3:0]                 idx3_q;
  frac_t                      frac3_q;

  assign x_ext  = XW'(x_coord_i);
  assign y_ext  = XW'(y_coord_i);
  assign xc     = CW'(x_ext);
  assign yc     = CW'(y_ext);
  assign col    = xc[CW-1:COORD_FRAC_BITS];
  assign row    = yc[CW-1:COORD_FRAC_BITS];
  assign h_base = HW'(row) * HW'(HASH_ROW_MUL) + HW'(col) * HW'(HASH_COL_MUL);

  // corners: top-left, top-right, bottom-right, bottom-left
  assign h_d[0] = h_base;
  assign h_d[1] = h_base + HW'(HASH_COL_MUL);
  assign h_d[2] = h_base + HW'(HASH_ROW_MUL + HASH_COL_MUL);
  assign h_d[3] = h_base + HW'(HASH_ROW_MUL);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod[k] = (2*HW)'(h1_q[k]) * (2*HW)'(RECIP);
      q_d[k]  = prod[k][2*HW-1:HW];
    end
  end

  // quotient estimate is low by at most one: one correction step
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rem[k] = h2_q[k] - HW'(q2_q[k] * HW'(TABLE_DEPTH));
      if (rem[k] >= HW'(TABLE_DEPTH)) begin
        idx_d[k] = AW'(rem[k] - HW'(TABLE_DEPTH));
      end else begin
        idx_d[k] = AW'(rem[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      cmd1_q     <= cmd_e'(cmd_i);
      wr1_q.idx  <= entry_index_i;
      wr1_q.gx   <= grad_x_i;
      wr1_q.gy   <= grad_y_i;
      h1_q       <= h_d;
      fx1_q      <= xc[COORD_FRAC_BITS-1:0];
      fy1_q      <= yc[COORD_FRAC_BITS-1:0];
      a2x1_q     <= A2W'(xc[COORD_FRAC_BITS-1:0]) * A2W'(xc[COORD_FRAC_BITS-1:0]);
      a2y1_q     <= A2W'(yc[COORD_FRAC_BITS-1:0]) * A2W'(yc[COORD_FRAC_BITS-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      cmd2_q <= cmd1_q;
      wr2_q  <= wr1_q;
      h2_q   <= h1_q;
      q2_q   <= q_d;
      fx2_q  <= fx1_q;
      fy2_q  <= fy1_q;
      ex2_q  <= ease(a2x1_q, fx1_q);
      ey2_q  <= ease(a2y1_q, fy1_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      cmd3_q     <= cmd2_q;
      wr3_q      <= wr2_q;
      idx3_q     <= idx_d;
      frac3_q.fx <= fx2_q;
      frac3_q.fy <= fy2_q;
      frac3_q.ex <= ex2_q;
      frac3_q.ey <= ey2_q;
    end
  end

  assign cmd_o  = cmd3_q;
  assign wr_o   = wr3_q;
  assign idx_o  = idx3_q;
  assign frac_o = frac3_q;

endmodule

>>> rtl/core/gn2d_grad_ram.sv
// Gradient table: two identical copies written together, each read at two corner
// addresses: four registered reads a cycle while enabled. Depends on gn2d_pkg.
module gn2d_grad_ram (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic                   wr_en_i,
  input  gn2d_pkg::wr_t          wr_i,
  input  gn2d_pkg::idx_t [3:0]   idx_i,
  input  gn2d_pkg::frac_t        frac_i,
  output gn2d_pkg::grad_t [3:0]  grad_o,
  output gn2d_pkg::frac_t        frac_o
);
  import gn2d_pkg::*;

  grad_t       mem_a_q [TABLE_DEPTH];
  grad_t       mem_b_q [TABLE_DEPTH];
  grad_t [3:0] grad_q;
  frac_t       frac_q;
  logic        wr_in_range;
  idx_t        wr_addr;
  grad_t       wr_data;

  assign wr_in_range = EXT_W'(wr_i.idx) < EXT_W'(TABLE_DEPTH);
  assign wr_addr     = AW'(EXT_W'(wr_i.idx));
  assign wr_data.gx  = wr_i.gx;
  assign wr_data.gy  = wr_i.gy;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_in_range) begin
      mem_a_q[wr_addr] <= wr_data;
      mem_b_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grad_q[0] <= mem_a_q[idx_i[0]];
      grad_q[1] <= mem_a_q[idx_i[1]];
      grad_q[2] <= mem_b_q[idx_i[2]];
      grad_q[3] <= mem_b_q[idx_i[3]];
      frac_q    <= frac_i;
    end
  end

  assign grad_o = grad_q;
  assign frac_o = frac_q;

endmodule

>>> rtl/core/gn2d_blend.sv
// Back stages: corner dot products, eased blend along x then y, final
// rounding and saturation into the output register. Depends on gn2d_pkg.
module gn2d_blend (
  input  logic                                              clk_i,
  input  logic [gn2d_pkg::NUM_STAGES-gn2d_pkg::RAM_STAGE-2:0] en_i,
  input  gn2d_pkg::grad_t [3:0]                             grad_i,
  input  gn2d_pkg::frac_t                                   frac_i,
  output logic signed [gn2d_pkg::NOISE_W-1:0]               noise_value_o
);
  import gn2d_pkg::*;

  function automatic logic signed [DW-1:0] dot(input grad_t g,
                                               input logic signed [OW-1:0] ox,
                                               input logic signed [OW-1:0] oy);
    return DW'(g.gx) * DW'(ox) + DW'(g.gy) * DW'(oy);
  endfunction

  function automatic logic signed [BW-1:0] scaled(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b,
                                                  input logic [COORD_FRAC_BITS:0] e);
    logic signed [DW:0]                diff;
    logic signed [COORD_FRAC_BITS+1:0] es;
    diff = (DW+1)'(b) - (DW+1)'(a);
    es   = signed'({1'b0, e});
    return BW'(diff) * BW'(es);
  endfunction

  function automatic logic signed [DW-1:0] settle(input logic signed [DW-1:0] a,
                                                  input logic signed [BW-1:0] p);
    return DW'(BW'(a) + ((p + BW'(HALF_F)) >>> COORD_FRAC_BITS));
  endfunction

  logic signed [OW-1:0]     oxp, oxm, oyp, oym;
  logic signed [DW-1:0]     d5_q [4];
  logic [COORD_FRAC_BITS:0] ex5_q, ey5_q, ey6_q, ey7_q;
  logic signed [BW-1:0]     p6_q [2];
  logic signed [DW-1:0]     a6_q [2];
  logic signed [DW-1:0]     top7_q, bot7_q, top8_q, v9_q;
  logic signed [BW-1:0]     py8_q;
  logic signed [DW-1:0]     rsum;
  logic signed [RW-1:0]     rnd;
  logic signed [NOISE_W-1:0] noise_d, noise_q;

  // offsets f and f - 1, the latter as the same bits under a negative sign bit
  assign oxp = {1'b0, frac_i.fx};
  assign oxm = {1'b1, frac_i.fx};
  assign oyp = {1'b0, frac_i.fy};
  assign oym = {1'b1, frac_i.fy};

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      d5_q[0] <= dot(grad_i[0], oxp, oyp);
      d5_q[1] <= dot(grad_i[1], oxm, oyp);
      d5_q[2] <= dot(grad_i[2], oxm, oym);
      d5_q[3] <= dot(grad_i[3], oxp, oym);
      ex5_q   <= frac_i.ex;
      ey5_q   <= frac_i.ey;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p6_q[0] <= scaled(d5_q[0], d5_q[1], ex5_q);
      p6_q[1] <= scaled(d5_q[3], d5_q[2], ex5_q);
      a6_q[0] <= d5_q[0];
      a6_q[1] <= d5_q[3];
      ey6_q   <= ey5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      top7_q <= settle(a6_q[0], p6_q[0]);
      bot7_q <= settle(a6_q[1], p6_q[1]);
      ey7_q  <= ey6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      py8_q  <= scaled(top7_q, bot7_q, ey7_q);
      top8_q <= top7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      v9_q <= settle(top8_q, py8_q);
    end
  end

  assign rsum = (v9_q + DW'(HALF_F)) >>> COORD_FRAC_BITS;
  assign rnd  = RW'(rsum);

  always_comb begin
    if (rnd > RW'(SAT_MAX)) begin
      noise_d = NOISE_W'(SAT_MAX);
    end else if (rnd < RW'(SAT_MIN)) begin
      noise_d = NOISE_W'(SAT_MIN);
    end else begin
      noise_d = NOISE_W'(rnd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      noise_q <= noise_d;
    end
  end

  assign noise_value_o = noise_q;

endmodule

>>> tb/tb_gradient_noise_2d.sv
// Self-checking testbench for gradient_noise_2d: loads gradients, samples points and
// predicts every noise value in a scoreboard class. Depends on gn2d_pkg and the RTL.
`timescale 1ns / 1ps

module tb_gradient_noise_2d;
  import gn2d_pkg::*;

  localparam int TOTAL_ITEMS = 2000;
  localparam int QUIET_LIMIT = 5000;

  class noise_tracker;
    typedef struct {
      logic [COORD_W-1:0]        x;
      logic [COORD_W-1:0]        y;
      logic signed [NOISE_W-1:0] value;
    } noise_exp_t;

    bit [31:0]  grads [TABLE_DEPTH];
    noise_exp_t expected_noise[$];
    int         errors    = 0;
    int         writes    = 0;
    int         samples   = 0;
    int         saturated = 0;

    static function int unsigned slot_of(longint unsigned row, longint unsigned col);
      return int'((row * HASH_ROW_MUL + col * HASH_COL_MUL) % TABLE_DEPTH);
    endfunction

    function longint shift_round(longint v, int sh);
      return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function longint slope_dot(longint unsigned row, longint unsigned col,
                               longint ox, longint oy);
      bit [31:0] e;
      e = grads[slot_of(row, col)];
      return longint'($signed(e[15:0])) * ox + longint'($signed(e[31:16])) * oy;
    endfunction

    function longint smooth(longint a);
      longint a2;
      longint s;
      a2 = a * a;
      s  = 3 * a2 * (64'sd1 <<< COORD_FRAC_BITS) - 2 * a2 * a;
      return (s + (64'sd1 <<< (2 * COORD_FRAC_BITS - 1))) >>> (2 * COORD_FRAC_BITS);
    endfunction

    function longint mix(longint a, longint b, longint e);
      return a + shift_round((b - a) * e, COORD_FRAC_BITS);
    endfunction

    function logic signed [NOISE_W-1:0] predict_noise(logic [COORD_W-1:0] xc,
                                                      logic [COORD_W-1:0] yc);
      longint unsigned xm, ym, row, col;
      longint one, fx, fy, ex, ey, d_tl, d_tr, d_br, d_bl, top, bot, v, r;
      one  = 64'sd1 <<< COORD_FRAC_BITS;
      xm   = longint'(xc) & ((64'd1 << CW) - 1);
      ym   = longint'(yc) & ((64'd1 << CW) - 1);
      col  = xm >> COORD_FRAC_BITS;
      row  = ym >> COORD_FRAC_BITS;
      fx   = longint'(xm & ((64'd1 << COORD_FRAC_BITS) - 1));
      fy   = longint'(ym & ((64'd1 << COORD_FRAC_BITS) - 1));
      d_tl = slope_dot(row, col, fx, fy);
      d_tr = slope_dot(row, col + 1, fx - one, fy);
      d_br = slope_dot(row + 1, col + 1, fx - one, fy - one);
      d_bl = slope_dot(row + 1, col, fx, fy - one);
      ex   = smooth(fx);
      ey   = smooth(fy);
      top  = mix(d_tl, d_tr, ex);
      bot  = mix(d_bl, d_br, ex);
      v    = mix(top, bot, ey);
      r    = shift_round(v, COORD_FRAC_BITS);
      if (r >= SAT_MAX || r <= SAT_MIN) saturated++;
      if (r > SAT_MAX) r = SAT_MAX;
      if (r < SAT_MIN) r = SAT_MIN;
      return NOISE_W'(r);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function void take_item(cmd_e c, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [ENTRY_W-1:0] idx, logic signed [GRAD_W-1:0] gx,
                            logic signed [GRAD_W-1:0] gy);
      noise_exp_t pending;
      if (c == CMD_WRITE) begin
        if (idx < TABLE_DEPTH) grads[idx] = {gy, gx};
        writes++;
      end else begin
        pending.x     = x;
        pending.y     = y;
        pending.value = predict_noise(x, y);
        expected_noise.insert(expected_noise.size(), pending);
        samples++;
      end
    endfunction

    task check_noise(logic signed [NOISE_W-1:0] value);
      noise_exp_t want;
      if (expected_noise.size() == 0) begin
        report_mismatch($sformatf("noise value %0d with no sample pending", value));
      end else begin
        want = expected_noise.pop_front();
        if (value !== want.value)
          report_mismatch($sformatf("noise at x=%06h y=%06h: got %0d, expected %0d",
                                    want.x, want.y, value, want.value));
      end
    endtask
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic                       cmd_i;
  logic [COORD_W-1:0]         x_coord_i;
  logic [COORD_W-1:0]         y_coord_i;
  logic [ENTRY_W-1:0]         entry_index_i;
  logic signed [GRAD_W-1:0]   grad_x_i;
  logic signed [GRAD_W-1:0]   grad_y_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [NOISE_W-1:0]  noise_value_o;

  noise_tracker tracker;
  bit           loaded [TABLE_DEPTH];
  bit           in_taken;
  int           quiet_cycles;
  int           items_sent;
  int           burst_left;

  gradient_noise_2d DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .x_coord_i    (x_coord_i),
    .y_coord_i    (y_coord_i),
    .entry_index_i(entry_index_i),
    .grad_x_i     (grad_x_i),
    .grad_y_i     (grad_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .noise_value_o(noise_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    in_taken = 1'b0;
    if (rst_ni) begin
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken)
        tracker.take_item(cmd_e'(cmd_i), x_coord_i, y_coord_i, entry_index_i,
                          grad_x_i, grad_y_i);
      if (out_valid_o && !out_stall_i) tracker.check_noise(noise_value_o);
      if (in_taken || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
    $display("tb_gradient_noise_2d NOT OK");
    $finish;
  end

  initial begin
    logic [15:0] pattern;
    int          span;
    int          mode;
    out_stall_i = 1'b0;
    span        = 0;
    mode        = 0;
    pattern     = '0;
    forever begin
      @(negedge clk_i);
      if (span == 0) begin
        span       = $urandom_range(50, 300);
        mode       = $urandom_range(0, 3);
        pattern    = 16'($urandom);
        pattern[0] = 1'b0;
      end
      span--;
      pattern     = {pattern[14:0], pattern[15]};
      out_stall_i = (mode != 0) && pattern[15];
    end
  end

  function automatic logic signed [GRAD_W-1:0] rand_slope();
    case ($urandom_range(0, 9))
      0:       return GRAD_W'(-32768);
      1:       return GRAD_W'(32767);
      2:       return GRAD_W'(16384);
      3:       return GRAD_W'(-16384);
      4, 5, 6: return GRAD_W'($urandom_range(0, 32768) - 16384);
      default: return GRAD_W'($urandom);
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    logic [COORD_INT_BITS-1:0]  cell_idx;
    logic [COORD_FRAC_BITS-1:0] frac;
    cell_idx = COORD_INT_BITS'($urandom);
    frac     = COORD_FRAC_BITS'($urandom);
    case ($urandom_range(0, 7))
      4, 5: begin
        case ($urandom_range(0, 4))
          0:       frac = '0;
          1:       frac = COORD_FRAC_BITS'(1);
          2:       frac = COORD_FRAC_BITS'(HALF_F - 1);
          3:       frac = COORD_FRAC_BITS'(HALF_F);
          default: frac = '1;
        endcase
      end
      6: cell_idx = $urandom_range(0, 1) ? '1 : '0;
      7: cell_idx = COORD_INT_BITS'($urandom_range(0, 3));
      default: ;
    endcase
    return {cell_idx, frac};
  endfunction

  // caller stands at a falling edge
  task automatic send_item(cmd_e c, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [ENTRY_W-1:0] idx, logic signed [GRAD_W-1:0] gx,
                           logic signed [GRAD_W-1:0] gy);
    int gap;
    cmd_i         = c;
    x_coord_i     = x;
    y_coord_i     = y;
    entry_index_i = idx;
    grad_x_i      = gx;
    grad_y_i      = gy;
    in_valid_i    = 1'b1;
    do @(negedge clk_i); while (!in_taken);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  task automatic write_slope(int unsigned idx, logic signed [GRAD_W-1:0] gx,
                             logic signed [GRAD_W-1:0] gy);
    loaded[idx] = 1'b1;
    send_item(CMD_WRITE, COORD_W'($urandom), COORD_W'($urandom), ENTRY_W'(idx), gx, gy);
  endtask

  // load any corner of the cell that has never been written, then sample
  task automatic sample_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    int unsigned row;
    int unsigned col;
    int unsigned slot;
    row = 32'(y >> COORD_FRAC_BITS);
    col = 32'(x >> COORD_FRAC_BITS);
    for (int dr = 0; dr < 2; dr++) begin
      for (int dc = 0; dc < 2; dc++) begin
        slot = noise_tracker::slot_of(row + dr, col + dc);
        if (!loaded[slot]) write_slope(slot, rand_slope(), rand_slope());
      end
    end
    send_item(CMD_EVAL, x, y, ENTRY_W'($urandom), rand_slope(), rand_slope());
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    do @(negedge clk_i); while (tracker.expected_noise.size() != 0);
  endtask

  initial begin
    int unsigned top;
    bit          paused;
    tracker       = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cmd_i         = CMD_WRITE;
    x_coord_i     = '0;
    y_coord_i     = '0;
    entry_index_i = '0;
    grad_x_i      = '0;
    grad_y_i      = '0;
    quiet_cycles  = 0;
    items_sent    = 0;
    paused        = 1'b0;
    burst_left    = $urandom_range(1, 40);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // corner cell at the origin, gradients chosen to drive the value to each limit
    write_slope(noise_tracker::slot_of(0, 0), GRAD_W'(32767), GRAD_W'(32767));
    write_slope(noise_tracker::slot_of(0, 1), GRAD_W'(-32768), GRAD_W'(32767));
    write_slope(noise_tracker::slot_of(1, 1), GRAD_W'(-32768), GRAD_W'(-32768));
    write_slope(noise_tracker::slot_of(1, 0), GRAD_W'(32767), GRAD_W'(-32768));
    sample_point(24'h000000, 24'h000000);
    sample_point(24'h000800, 24'h000800);
    sample_point(24'h000FFF, 24'h000FFF);
    sample_point(24'h000800, 24'h000000);
    sample_point(24'h000000, 24'h000FFF);
    write_slope(noise_tracker::slot_of(0, 0), GRAD_W'(-32768), GRAD_W'(-32768));
    write_slope(noise_tracker::slot_of(0, 1), GRAD_W'(32767), GRAD_W'(-32768));
    write_slope(noise_tracker::slot_of(1, 1), GRAD_W'(32767), GRAD_W'(32767));
    write_slope(noise_tracker::slot_of(1, 0), GRAD_W'(-32768), GRAD_W'(32767));
    sample_point(24'h000800, 24'h000800);

    // last cell of the grid: the neighbour row and column run past the format
    top = (1 << COORD_INT_BITS) - 1;
    write_slope(noise_tracker::slot_of(top, top), GRAD_W'(16384), GRAD_W'(-16384));
    write_slope(noise_tracker::slot_of(top, top + 1), GRAD_W'(-16384), GRAD_W'(16384));
    write_slope(noise_tracker::slot_of(top + 1, top + 1), GRAD_W'(16384), GRAD_W'(16384));
    write_slope(noise_tracker::slot_of(top + 1, top), GRAD_W'(-16384), GRAD_W'(-16384));
    sample_point(24'hFFFFFF, 24'hFFFFFF);
    sample_point(24'hFFF800, 24'hFFF001);
    write_slope(TABLE_DEPTH - 1, GRAD_W'(0), GRAD_W'(0));
    drain();

    while (items_sent < TOTAL_ITEMS) begin
      if (!paused && items_sent >= TOTAL_ITEMS / 2) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 3) == 0)
        write_slope($urandom_range(0, TABLE_DEPTH - 1), rand_slope(), rand_slope());
      else
        sample_point(pick_coord(), pick_coord());
    end

    drain();
    repeat (2 * NUM_STAGES) @(negedge clk_i);
    if (tracker.expected_noise.size() != 0)
      tracker.report_mismatch($sformatf("%0d noise samples never returned",
                                        tracker.expected_noise.size()));
    $display("run: %0d items, %0d gradient writes, %0d noise samples (%0d at a limit)",
             items_sent, tracker.writes, tracker.samples, tracker.saturated);
    $display("mismatches: %0d", tracker.errors);
    if (tracker.errors == 0) begin
      $display("tb_gradient_noise_2d OK");
    end else begin
      $display("tb_gradient_noise_2d NOT OK");
    end
    $finish;
  end

endmodule
